>>> src/b2da_pkg.sv
// Shared types, constants and the control store of the binary to decimal ASCII stream.
`default_nettype none
package b2da_pkg;

  localparam int unsigned ValueBitsDef = 32;
  localparam logic [5:0]  AsciiZero    = 6'd48;
  localparam logic [3:0]  DabbleLimit  = 4'd5;
  localparam logic [3:0]  DabbleAdd    = 4'd3;

  // Decimal digits needed for an n-bit unsigned value: floor(n * log10(2)) + 1.
  function automatic int unsigned num_digits(input int unsigned bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  typedef enum logic [1:0] {
    STEP_IDLE   = 2'd0,
    STEP_DABBLE = 2'd1,
    STEP_SKIP   = 2'd2,
    STEP_EMIT   = 2'd3
  } step_e;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DABBLE = 2'd1,
    OP_SKIP   = 2'd2,
    OP_EMIT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    COND_ACCEPT    = 2'd0,
    COND_BITS_DONE = 2'd1,
    COND_NO_LEAD   = 2'd2,
    COND_LAST_SENT = 2'd3
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
    logic  in_ready;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic bits_last;   // final shift of the conversion
    logic lead_zero;   // top digit is a leading zero that may be dropped
    logic last_digit;  // one digit left to send
    logic out_free;    // output register can take a word
  } dp_stat_t;

  // Control store: on its condition a step jumps to its target, else it repeats.
  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:   w = '{op: OP_LOAD,   cond: COND_ACCEPT,    target: STEP_DABBLE, in_ready: 1'b1};
      STEP_DABBLE: w = '{op: OP_DABBLE, cond: COND_BITS_DONE, target: STEP_SKIP,   in_ready: 1'b0};
      STEP_SKIP:   w = '{op: OP_SKIP,   cond: COND_NO_LEAD,   target: STEP_EMIT,   in_ready: 1'b0};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_LAST_SENT, target: STEP_IDLE,   in_ready: 1'b0};
      default:     w = '{op: OP_LOAD,   cond: COND_ACCEPT,    target: STEP_DABBLE, in_ready: 1'b1};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/b2da_datapath.sv
// Shift-and-add-3 datapath, digit shifter and output register of the converter.
`default_nettype none
module b2da_datapath
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_ctrl_t              ctrl_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  out_ready_i,
  output dp_stat_t                   stat_o,
  output logic                       out_valid_o,
  output logic [5:0]                 out_char_o,
  output logic                       out_last_o
);

  localparam int unsigned NumDig = num_digits(VALUE_BITS);
  localparam int unsigned BcdW   = 4 * NumDig;
  localparam int unsigned CntW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned DigW   = $clog2(NumDig + 1);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DigW-1:0]       dig_q, dig_d;
  logic                  out_valid_q, out_valid_d;
  logic [5:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic [3:0]            top_digit;

  assign top_digit = bcd_q[BcdW-1 -: 4];

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[4*i +: 4] >= DabbleLimit) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + DabbleAdd;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign stat_o.bits_last  = (cnt_q == CntW'(1));
  assign stat_o.lead_zero  = (top_digit == 4'd0) && (dig_q != DigW'(1));
  assign stat_o.last_digit = (dig_q == DigW'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = CntW'(VALUE_BITS);
      dig_d = DigW'(NumDig);
    end
    if (ctrl_i.dabble) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
    if (ctrl_i.skip) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
      dig_d = dig_q - DigW'(1);
    end
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = AsciiZero + {2'b00, top_digit};
      out_last_d  = (dig_q == DigW'(1));
      bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
      dig_d       = dig_q - DigW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dig_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      dig_q       <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

>>> src/binary_to_decimal_ascii_stream.sv
// Top level: microcoded step sequencer driving the binary to decimal ASCII datapath.
// Sequence per value: the load step, the one-bit-per-cycle shift-and-add-3 loop, the skip
//   step that drops leading zero digits and the emit step that sends each remaining digit.
// A new value is taken only in the idle step, after the last digit word of the previous value
//   has gone into the output register.
// One digit word per cycle leaves the output register while the sink is ready; last digit word carries tlast.
// Reset: asynchronous, active low; returns the sequencer to idle and empties the output.
`default_nettype none
module binary_to_decimal_ascii_stream
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // [VALUE_BITS-1:0] value
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [7:0]                              m_axis_tdata,  // [5:0] digit_char
  output logic                                    m_axis_tlast   // last_digit
);

  step_e    step_q, step_d;
  ucode_t   uword;
  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     cond_ok;
  logic [5:0] out_char;

  assign uword = ucode_rom(step_q);

  always_comb begin
    unique case (uword.cond)
      COND_ACCEPT:    cond_ok = s_axis_tvalid && uword.in_ready;
      COND_BITS_DONE: cond_ok = stat.bits_last;
      COND_NO_LEAD:   cond_ok = !stat.lead_zero;
      COND_LAST_SENT: cond_ok = stat.out_free && stat.last_digit;
      default:        cond_ok = 1'b0;
    endcase
  end

  // Next step: jump on condition, else repeat.
  always_comb begin
    step_d = step_q;
    if (cond_ok) begin
      step_d = uword.target;
    end
  end

  // Decode the control word into datapath strobes.
  always_comb begin
    ctrl = '0;
    unique case (uword.op)
      OP_LOAD:   ctrl.load   = s_axis_tvalid && uword.in_ready;
      OP_DABBLE: ctrl.dabble = 1'b1;
      OP_SKIP:   ctrl.skip   = stat.lead_zero;
      OP_EMIT:   ctrl.emit   = stat.out_free;
      default:   ctrl        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign s_axis_tready = uword.in_ready;

  b2da_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .value_i    (s_axis_tdata[VALUE_BITS-1:0]),
    .out_ready_i(m_axis_tready),
    .stat_o     (stat),
    .out_valid_o(m_axis_tvalid),
    .out_char_o (out_char),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_char};

endmodule
`default_nettype wire

>>> src/b2da_checker.sv
// Port-level checker for the binary to decimal ASCII stream, bound to the top level.
`default_nettype none
module b2da_checker
  import b2da_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  logic in_number_q;

  // Track whether a number is part way out (a word went without tlast).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      in_number_q <= !m_axis_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00 &&
      m_axis_tdata[5:0] >= AsciiZero && m_axis_tdata[5:0] <= AsciiZero + 6'd9)
    else $error("output word is not a decimal digit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before conversion");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !in_number_q && m_axis_tdata[5:0] == AsciiZero |-> m_axis_tlast)
    else $error("leading zero digit sent");

endmodule

bind binary_to_decimal_ascii_stream b2da_checker u_b2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire

>>> tb/binary_to_decimal_ascii_stream_test.sv
// Testbench for the binary to decimal ASCII stream: directed table plus random values.
module binary_to_decimal_ascii_stream_test;
  import b2da_pkg::AsciiZero;

  localparam int DirCount   = 20;
  localparam int RandCount  = 190;
  localparam int HoldStart  = 1500;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [5:0] ch;
    logic       is_last;
  } digit_word_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [31:0] value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [5:0] digit_char
  logic        m_axis_tlast;        // last_digit

  digit_word_t pending_digits [$];
  int          mismatch_count = 0;
  int          send_gap_max   = 0;
  int          burst_left     = 0;

  // Rows with text carry the decimal string; empty text means use the predictor.
  logic [31:0] dir_value [DirCount] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295, 32'd4294967294,
    32'd1000000000, 32'd999999999, 32'd2147483648, 32'd2147483647, 32'hAAAAAAAA,
    32'h55555555, 32'd4000000000, 32'd1234567890, 32'hDEADBEEF, 32'd65535,
    32'd100000, 32'd0
  };
  string dir_text [DirCount] = '{
    "0", "1", "9", "10", "99", "100", "4294967295", "4294967294",
    "1000000000", "999999999", "2147483648", "2147483647", "",
    "", "4000000000", "1234567890", "", "65535",
    "", "0"
  };

  binary_to_decimal_ascii_stream u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Split the value into decimal digits and queue them most significant first.
  function automatic void queue_decimal_digits(input logic [31:0] value);
    logic [3:0]        digs [10];
    longint unsigned   rest;
    int                n;
    int                k;
    digit_word_t       w;
    rest = value;
    n = 0;
    do begin
      digs[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    for (k = n - 1; k >= 0; k--) begin
      w.ch = AsciiZero + 6'(digs[k]);
      w.is_last = (k == 0);
      pending_digits.push_back(w);
    end
  endfunction

  function automatic void queue_typed_digits(input string text);
    int          k;
    byte         c;
    digit_word_t w;
    for (k = 0; k < text.len(); k++) begin
      c = text[k];
      w.ch = c[5:0];
      w.is_last = (k == text.len() - 1);
      pending_digits.push_back(w);
    end
  endfunction

  // Pick a digit count first so every length from 1 to 10 shows up often.
  function automatic logic [31:0] rand_value();
    int              d;
    int              pick;
    longint unsigned lo;
    longint unsigned hi;
    pick = $urandom_range(9, 0);
    d = $urandom_range(10, 1);
    lo = 1;
    repeat (d - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
    if (pick < 2) return $urandom;
    if (pick == 2) return lo[31:0];
    if (pick == 3) return (d == 10) ? 32'hFFFFFFFF : hi[31:0];
    if (d == 1) lo = 0;
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  // Offer one word, idling between bursts; return at the edge it is taken.
  task automatic send_value(input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = (send_gap_max == 0) ? 0 : $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(8, 1);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // Receiver: rotate through stall patterns, with one long hold-off to back up the input.
  initial begin : drain_side
    int rx_cycle;
    int hold_left;
    int mode;
    rx_cycle = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle == HoldStart) hold_left = HoldCycles;
      mode = (rx_cycle / 512) % 3;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (mode == 0) begin
        m_axis_tready <= 1'b1;
      end else if (mode == 1) begin
        m_axis_tready <= ($urandom_range(9, 0) >= 3);
      end else begin
        m_axis_tready <= ((rx_cycle % 7) >= 3);
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    digit_word_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit word: digit_char %0d last_digit %0b",
               m_axis_tdata[5:0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata[5:0] !== want.ch) begin
          $error("digit_char expected %0d actual %0d", want.ch, m_axis_tdata[5:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("last_digit expected %0b actual %0b", want.is_last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int          i;
    logic [31:0] value;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_max = 3;
    for (i = 0; i < DirCount; i++) begin
      send_value(dir_value[i]);
      if (dir_text[i] != "") queue_typed_digits(dir_text[i]);
      else queue_decimal_digits(dir_value[i]);
    end

    // Change the sender's idling every 40 words; some stretches run without gaps.
    for (i = 0; i < RandCount; i++) begin
      if (i % 40 == 0) send_gap_max = (i % 80 == 0) ? 0 : $urandom_range(60, 1);
      value = rand_value();
      send_value(value);
      queue_decimal_digits(value);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("binary_to_decimal_ascii_stream_test OK");
    end else begin
      $display("binary_to_decimal_ascii_stream_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("binary_to_decimal_ascii_stream_test NOT OK");
    $finish;
  end

endmodule

>>> files.f
src/b2da_pkg.sv
src/b2da_datapath.sv
src/binary_to_decimal_ascii_stream.sv
src/b2da_checker.sv
tb/binary_to_decimal_ascii_stream_test.sv
